// ----- rtl/ihrw_pkg.sv -----
// ============================================================================
// ihrw_pkg
// Shared types, constants and helper functions of the HEX record writer.
// ============================================================================
package ihrw_pkg;

    // Data bytes per record line, and the depth of the line buffer.
    localparam int LINE_BYTES = 32;
    localparam int BUF_DEPTH  = 32;
    localparam int BUF_AW     = $clog2(BUF_DEPTH);

    // Widths of the ports.
    localparam int ADDR_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int LIMIT_W = 20;
    localparam int TEXT_W  = 64;
    localparam int CNT_W   = 4;
    localparam int IDX_W   = 2;
    localparam int CFG_W   = 20;

    // Line fill count (0 to BUF_DEPTH) and character position in a record.
    localparam int LCNT_W = 6;
    localparam int POS_W  = 7;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_ENTRY_LIMIT = 2'd0;
    localparam logic [IDX_W-1:0] REG_GO_ENABLE   = 2'd1;
    localparam logic [IDX_W-1:0] REG_GO_ADDRESS  = 2'd2;

    localparam logic [LIMIT_W-1:0] ENTRY_LIMIT_RST = 20'd65536;

    // Input operation codes.
    localparam logic OP_DATA   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // ASCII characters that appear as literals in records.
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_NL    = 8'h0A;

    // Record types that the character sequencer can produce.
    typedef enum logic [1:0] {
        REC_DATA,
        REC_GO,
        REC_EOF
    } t_rec_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      capture;   // input transfer this cycle
        logic      acc_inc;   // count the held byte against the entry limit
        logic      place;     // write the held byte into the open line
        logic      emit;      // run the character sequencer
        t_rec_kind kind;      // record being produced
        logic      last;      // record closes the results of this item
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op;          // held operation
        logic limit_hit;   // entry limit reached for this image
        logic brk;         // held address does not follow the previous one
        logic line_nz;     // open line holds at least one byte
        logic place_full;  // placing the held byte fills the line
        logic go_en;       // start record enabled
        logic rec_done;    // last character of the record stepped this cycle
    } t_dp_stat;

    // ASCII hex digit of a nibble, upper case.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        if (nib < 4'd10) begin
            return 8'h30 + wide;
        end else begin
            return 8'h37 + wide;
        end
    endfunction

    // Nibble k of a 16-bit value, k = 0 being the most significant.
    function automatic logic [3:0] nib16(input logic [15:0] v, input logic [1:0] k);
        logic [3:0] res;
        case (k)
            2'd0:    res = v[15:12];
            2'd1:    res = v[11:8];
            2'd2:    res = v[7:4];
            default: res = v[3:0];
        endcase
        return res;
    endfunction

endpackage

// ----- rtl/intel_hex_record_writer_unit.sv -----
// ============================================================================
// intel_hex_record_writer_unit
// Turns (address, byte) transfers into Intel HEX text, up to eight characters
// per output transfer, with data, start segment and end-of-file records.
// ============================================================================
//
//  Channel  Handshake                Payload (width)                                  Dir
//  in       i_in_valid/o_in_ready    i_op(1) i_addr(16) i_value(8)                    sink
//  out      o_out_valid/i_out_ready  o_text(64) o_char_count(4) o_line_end o_last     source
//  cfg      i_cfg_we                 i_cfg_index(2) i_cfg_data(20)                    sink
//
//  A data byte that closes no line passes the transfer, an evaluation state
//  and the buffer write. A data record of n bytes has 12 + 2n characters,
//  the start segment record 20 and the end-of-file record 12, stepped one
//  character per cycle unless the output stalls. Reset is synchronous and
//  leaves the line buffer uncleared. The sequencer holds while a finished
//  chunk waits in the output register; input transfers come only between items.
//
module intel_hex_record_writer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ihrw_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [ihrw_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_op,
    input  logic [ihrw_pkg::ADDR_W-1:0]   i_addr,
    input  logic [ihrw_pkg::BYTE_W-1:0]   i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ihrw_pkg::TEXT_W-1:0]   o_text,
    output logic [ihrw_pkg::CNT_W-1:0]    o_char_count,
    output logic                          o_line_end,
    output logic                          o_last
);
    import ihrw_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // The controller decides which record to produce and when to take the
    // next transfer; it sees the datapath only through the status struct.
    ihrw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the open line, generates record characters and
    // packs them into the output register.
    ihrw_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_op         (i_op),
        .i_addr       (i_addr),
        .i_value      (i_value),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_text       (o_text),
        .o_char_count (o_char_count),
        .o_line_end   (o_line_end),
        .o_last       (o_last)
    );

    // No new transfer is taken while a record is being produced.
    a_no_accept_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_cmd.emit)
        else $error("input ready while the record sequencer runs");

    // The closing chunk of an item always ends a record.
    a_last_ends_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> o_line_end)
        else $error("last chunk does not end a record");

    // A chunk carries one to eight characters.
    a_char_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_char_count != 4'd0 && o_char_count <= 4'd8))
        else $error("chunk character count out of range");

    // After the end-of-file record the block is ready for a new image.
    a_eof_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stat.rec_done && w_cmd.kind == REC_EOF) |=> o_in_ready)
        else $error("block not ready after end-of-file record");

endmodule

// ----- rtl/ihrw_ctrl.sv -----
// ============================================================================
// ihrw_ctrl
// Controller: sequences item evaluation, line flushes and closing records.
// ============================================================================
module ihrw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ihrw_pkg::t_dp_stat i_stat,
    output ihrw_pkg::t_dp_cmd  o_cmd
);
    import ihrw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_BRK,
        S_PLACE,
        S_FULL,
        S_FIN,
        S_GO,
        S_EOF
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.kind     = REC_DATA;
        o_in_ready     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_stat.op == OP_FINISH) begin
                    if (i_stat.line_nz) begin
                        n_state = S_FIN;
                    end else if (i_stat.go_en) begin
                        n_state = S_GO;
                    end else begin
                        n_state = S_EOF;
                    end
                end else if (i_stat.limit_hit) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.acc_inc = 1'b1;
                    n_state       = i_stat.brk ? S_BRK : S_PLACE;
                end
            end
            S_BRK: begin
                // The new byte starts a fresh line; it fills it only for one-byte lines.
                o_cmd.emit = 1'b1;
                o_cmd.kind = REC_DATA;
                o_cmd.last = 1'(LINE_BYTES > 1);
                if (i_stat.rec_done) begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = i_stat.place_full ? S_FULL : S_IDLE;
            end
            S_FULL: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = REC_DATA;
                o_cmd.last = 1'b1;
                if (i_stat.rec_done) begin
                    n_state = S_IDLE;
                end
            end
            S_FIN: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = REC_DATA;
                if (i_stat.rec_done) begin
                    n_state = i_stat.go_en ? S_GO : S_EOF;
                end
            end
            S_GO: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = REC_GO;
                if (i_stat.rec_done) begin
                    n_state = S_EOF;
                end
            end
            S_EOF: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = REC_EOF;
                o_cmd.last = 1'b1;
                if (i_stat.rec_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/ihrw_dp.sv -----
// ============================================================================
// ihrw_dp
// Datapath: configuration, line state, line buffer, character sequencer,
// chunk packer and output register.
// ============================================================================
module ihrw_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ihrw_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [ihrw_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_op,
    input  logic [ihrw_pkg::ADDR_W-1:0]   i_addr,
    input  logic [ihrw_pkg::BYTE_W-1:0]   i_value,
    input  ihrw_pkg::t_dp_cmd             i_cmd,
    output ihrw_pkg::t_dp_stat            o_stat,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ihrw_pkg::TEXT_W-1:0]   o_text,
    output logic [ihrw_pkg::CNT_W-1:0]    o_char_count,
    output logic                          o_line_end,
    output logic                          o_last
);
    import ihrw_pkg::*;

    // Configuration registers.
    logic [LIMIT_W-1:0] r_entry_limit;
    logic               r_go_enable;
    logic [ADDR_W-1:0]  r_go_address;

    // Held input item.
    logic               r_op;
    logic [ADDR_W-1:0]  r_addr;
    logic [BYTE_W-1:0]  r_val;

    // Line and image state.
    logic [LCNT_W-1:0]  r_line_count;
    logic [ADDR_W-1:0]  r_line_start;
    logic [ADDR_W-1:0]  r_prev_addr;
    logic [BYTE_W-1:0]  r_data_sum;
    logic [LIMIT_W-1:0] r_acc_count;

    // Line buffer and its read side.
    logic [BYTE_W-1:0]  r_line_mem [BUF_DEPTH];
    logic [BYTE_W-1:0]  r_rd_data;
    logic [BUF_AW-1:0]  r_byte_idx;
    logic [BUF_AW-1:0]  n_byte_idx;

    // Character sequencer and chunk packer.
    logic [POS_W-1:0]   r_pos;
    logic [2:0]         r_asm_cnt;
    logic [TEXT_W-1:0]  r_asm;

    // Output register.
    logic               r_out_valid;
    logic [TEXT_W-1:0]  r_text;
    logic [CNT_W-1:0]   r_char_count;
    logic               r_line_end;
    logic               r_last;

    logic [POS_W-1:0]   w_n2;
    logic [POS_W-1:0]   w_dend;
    logic [POS_W-1:0]   w_doff;
    logic [BYTE_W-1:0]  w_data_ck;
    logic [BYTE_W-1:0]  w_go_ck;
    logic [BYTE_W-1:0]  w_cnt8;
    logic               w_is_hex;
    logic [3:0]         w_nib;
    logic [7:0]         w_lit;
    logic [7:0]         w_char;
    logic               w_rec_end;
    logic               w_in_data;
    logic               w_chunk_done;
    logic               w_step;
    logic [TEXT_W-1:0]  w_asm_next;

    // ------------------------------------------------------------------
    // Record arithmetic.
    // ------------------------------------------------------------------
    assign w_cnt8    = {{(BYTE_W-LCNT_W){1'b0}}, r_line_count};
    assign w_n2      = {r_line_count, 1'b0};
    assign w_dend    = 7'd9 + w_n2;
    assign w_doff    = r_pos - 7'd9;
    assign w_data_ck = 8'h00 - (r_data_sum + w_cnt8 + r_line_start[15:8]
                                + r_line_start[7:0]);
    assign w_go_ck   = 8'h00 - (8'd7 + r_go_address[15:8] + r_go_address[7:0]);

    // Character at the current position of the selected record.
    always_comb begin
        w_is_hex  = 1'b0;
        w_nib     = 4'h0;
        w_lit     = CH_ZERO;
        w_rec_end = 1'b0;
        w_in_data = 1'b0;
        case (i_cmd.kind)
            REC_DATA: begin
                w_rec_end = (r_pos == w_dend + 7'd2);
                if (r_pos == 7'd0) begin
                    w_lit = CH_COLON;
                end else if (r_pos <= 7'd2) begin
                    w_is_hex = 1'b1;
                    w_nib    = (r_pos == 7'd1) ? w_cnt8[7:4] : w_cnt8[3:0];
                end else if (r_pos <= 7'd6) begin
                    w_is_hex = 1'b1;
                    w_nib    = nib16(r_line_start, 2'(r_pos - 7'd3));
                end else if (r_pos <= 7'd8) begin
                    w_lit = CH_ZERO;
                end else if (r_pos < w_dend) begin
                    w_is_hex  = 1'b1;
                    w_in_data = 1'b1;
                    w_nib     = w_doff[0] ? r_rd_data[3:0] : r_rd_data[7:4];
                end else if (r_pos == w_dend) begin
                    w_is_hex = 1'b1;
                    w_nib    = w_data_ck[7:4];
                end else if (r_pos == w_dend + 7'd1) begin
                    w_is_hex = 1'b1;
                    w_nib    = w_data_ck[3:0];
                end else begin
                    w_lit = CH_NL;
                end
            end
            REC_GO: begin
                w_rec_end = (r_pos == 7'd19);
                if (r_pos == 7'd0) begin
                    w_lit = CH_COLON;
                end else if (r_pos == 7'd2) begin
                    w_lit = CH_FOUR;
                end else if (r_pos == 7'd8) begin
                    w_lit = CH_THREE;
                end else if (r_pos <= 7'd12) begin
                    w_lit = CH_ZERO;
                end else if (r_pos <= 7'd16) begin
                    w_is_hex = 1'b1;
                    w_nib    = nib16(r_go_address, 2'(r_pos - 7'd13));
                end else if (r_pos == 7'd17) begin
                    w_is_hex = 1'b1;
                    w_nib    = w_go_ck[7:4];
                end else if (r_pos == 7'd18) begin
                    w_is_hex = 1'b1;
                    w_nib    = w_go_ck[3:0];
                end else begin
                    w_lit = CH_NL;
                end
            end
            REC_EOF: begin
                w_rec_end = (r_pos == 7'd11);
                if (r_pos == 7'd0) begin
                    w_lit = CH_COLON;
                end else if (r_pos == 7'd8) begin
                    w_lit = CH_ONE;
                end else if (r_pos == 7'd9 || r_pos == 7'd10) begin
                    w_lit = CH_F;
                end else if (r_pos == 7'd11) begin
                    w_lit = CH_NL;
                end else begin
                    w_lit = CH_ZERO;
                end
            end
            default: begin
                w_rec_end = 1'b1;
                w_lit     = CH_NL;
            end
        endcase
        w_char = w_is_hex ? hex_char(w_nib) : w_lit;
    end

    // The sequencer holds whenever a finished chunk has nowhere to go.
    assign w_chunk_done = (r_asm_cnt == 3'd7) || w_rec_end;
    assign w_step       = i_cmd.emit && !(w_chunk_done && r_out_valid && !i_out_ready);

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_asm_next[8*i +: 8] = (r_asm_cnt == 3'(i)) ? w_char : r_asm[8*i +: 8];
        end
    end

    // Byte index of the buffer read; advances after the low nibble of a byte.
    always_comb begin
        n_byte_idx = r_byte_idx;
        if (w_step) begin
            if (w_rec_end) begin
                n_byte_idx = '0;
            end else if (w_in_data && w_doff[0]) begin
                n_byte_idx = r_byte_idx + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Line buffer.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.place && !r_line_count[LCNT_W-1]) begin
            r_line_mem[r_line_count[BUF_AW-1:0]] <= r_val;
        end
        r_rd_data <= r_line_mem[n_byte_idx];
    end

    // Held item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_op;
            r_addr <= i_addr;
            r_val  <= i_value;
        end
    end

    // ------------------------------------------------------------------
    // Configuration, line state, sequencer and output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_limit <= ENTRY_LIMIT_RST;
            r_go_enable   <= 1'b0;
            r_go_address  <= '0;
            r_line_count  <= '0;
            r_line_start  <= '0;
            r_prev_addr   <= '0;
            r_data_sum    <= '0;
            r_acc_count   <= '0;
            r_byte_idx    <= '0;
            r_pos         <= '0;
            r_asm_cnt     <= '0;
            r_asm         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_ENTRY_LIMIT: r_entry_limit <= i_cfg_data[LIMIT_W-1:0];
                    REG_GO_ENABLE:   r_go_enable   <= i_cfg_data[0];
                    REG_GO_ADDRESS:  r_go_address  <= i_cfg_data[ADDR_W-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.acc_inc) begin
                r_acc_count <= r_acc_count + 1'b1;
            end

            if (i_cmd.place) begin
                r_line_count <= r_line_count + 1'b1;
                r_prev_addr  <= r_addr;
                if (r_line_count == '0) begin
                    r_line_start <= r_addr;
                    r_data_sum   <= r_val;
                end else begin
                    r_data_sum <= r_data_sum + r_val;
                end
            end

            r_byte_idx <= n_byte_idx;

            if (w_step) begin
                if (w_rec_end) begin
                    r_pos <= '0;
                    if (i_cmd.kind == REC_DATA) begin
                        r_line_count <= '0;
                        r_data_sum   <= '0;
                    end else if (i_cmd.kind == REC_EOF) begin
                        r_line_count <= '0;
                        r_line_start <= '0;
                        r_prev_addr  <= '0;
                        r_data_sum   <= '0;
                        r_acc_count  <= '0;
                    end
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
                if (w_chunk_done) begin
                    r_asm_cnt <= '0;
                    r_asm     <= '0;
                end else begin
                    r_asm_cnt <= r_asm_cnt + 1'b1;
                    r_asm     <= w_asm_next;
                end
            end

            if (w_step && w_chunk_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (w_step && w_chunk_done) begin
            r_text       <= w_asm_next;
            r_char_count <= {1'b0, r_asm_cnt} + 4'd1;
            r_line_end   <= w_rec_end;
            r_last       <= w_rec_end && i_cmd.last;
        end
    end

    // Status to the controller.
    always_comb begin
        o_stat            = '0;
        o_stat.op         = r_op;
        o_stat.limit_hit  = (r_acc_count >= r_entry_limit);
        o_stat.brk        = (r_line_count != '0)
                            && ((r_prev_addr == 16'hFFFF) || (r_addr != r_prev_addr + 16'd1));
        o_stat.line_nz    = (r_line_count != '0);
        o_stat.place_full = (r_line_count >= LCNT_W'(LINE_BYTES - 1));
        o_stat.go_en      = r_go_enable;
        o_stat.rec_done   = w_step && w_rec_end;
    end

    assign o_out_valid  = r_out_valid;
    assign o_text       = r_text;
    assign o_char_count = r_char_count;
    assign o_line_end   = r_line_end;
    assign o_last       = r_last;

endmodule

// ----- tb/testbench.sv -----
// ============================================================================
// testbench
// Self-checking bench for intel_hex_record_writer_unit. A short table of
// directed steps covers the corner cases: address wrap, breaks, an empty
// finish, the start segment record and the entry limit. Randomized images
// of sequential byte runs and scattered bytes follow. Each transfer on the
// input channel runs through a behavioral predictor, and every output
// transfer is compared field by field with the oldest predicted chunk.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ihrw_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 350;
    localparam int REPORT_MAX     = 10;

    // Register index that decodes to nothing; writes to it must be ignored.
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    // Record type bytes and the payload length of a start segment record.
    localparam logic [7:0] REC_TYPE_DATA  = 8'h00;
    localparam logic [7:0] REC_TYPE_EOF   = 8'h01;
    localparam logic [7:0] REC_TYPE_START = 8'h03;
    localparam logic [7:0] START_LENGTH   = 8'h04;

    // Upper-case hex digits, digit 0 in the top byte.
    localparam logic [127:0] HEX_DIGITS = "0123456789ABCDEF";

    // One output transfer as the block presents it.
    typedef struct packed {
        logic [TEXT_W-1:0] text;
        logic [CNT_W-1:0]  count;
        logic              line_end;
        logic              last;
    } t_hex_chunk;

    // Rows of the directed table either write a register or send an item.
    // An item row may carry a hand-written expectation instead of the
    // predicted one.
    typedef enum logic {
        STEP_ITEM,
        STEP_REG
    } t_step_kind;

    typedef enum logic [2:0] {
        TYPED_NONE,
        TYPED_EOF,
        TYPED_FFFF_LINE,
        TYPED_GO_FFFF,
        TYPED_GO_ZERO
    } t_typed_sel;

    typedef struct packed {
        t_step_kind         kind;
        logic               op_bit;
        logic [ADDR_W-1:0]  addr_val;
        logic [BYTE_W-1:0]  data_val;
        logic [IDX_W-1:0]   reg_idx;
        logic [CFG_W-1:0]   reg_data;
        t_typed_sel         typed;
    } t_directed_step;

    localparam int DIRECTED_STEPS = 27;

    localparam t_directed_step DIRECTED [DIRECTED_STEPS] = '{
        // Finish straight after reset: only the end-of-file record.
        '{STEP_ITEM, OP_FINISH, 16'h0000, 8'h00, REG_ENTRY_LIMIT, 20'h0, TYPED_EOF},
        // One byte at the top address, flushed by the finish.
        '{STEP_ITEM, OP_DATA,   16'hFFFF, 8'hFF, REG_ENTRY_LIMIT, 20'h0, TYPED_NONE},
        '{STEP_ITEM, OP_FINISH, 16'h0000, 8'h00, REG_ENTRY_LIMIT, 20'h0, TYPED_FFFF_LINE},
        // A run across the address wrap: 0x0000 breaks the line.
        '{STEP_ITEM, OP_DATA,   16'hFFFE, 8'h00, REG_ENTRY_LIMIT, 20'h0, TYPED_NONE},
        '{STEP_ITEM, OP_DATA,   16'hFFFF, 8'h01, REG_ENTRY_LIMIT, 20'h0, TYPED_NONE},
        '{STEP_ITEM, OP_DATA,   16'h0000, 8'h80, REG_ENTRY_LIMIT, 20'h0, TYPED_NONE},
        '{STEP_ITEM, OP_DATA,   16'h0001, 8'h7F, REG_ENTRY_LIMIT, 20'h0, TYPED_NONE},
        // Jumps forward and backward both break the line.
        '{STEP_ITEM, OP_DATA,   16'h1234, 8'hAA, REG_ENTRY_LIMIT, 20'h0, TYPED_NONE},
        '{STEP_ITEM, OP_DATA,   16'h1233, 8'h55, REG_ENTRY_LIMIT, 20'h0, TYPED_NONE},
        '{STEP_ITEM, OP_FINISH, 16'hFFFF, 8'hFF, REG_ENTRY_LIMIT, 20'h0, TYPED_NONE},
        // Start segment record with the largest instruction pointer.
        '{STEP_REG,  OP_DATA,   16'h0000, 8'h00, REG_GO_ENABLE,   20'h1, TYPED_NONE},
        '{STEP_REG,  OP_DATA,   16'h0000, 8'h00, REG_GO_ADDRESS,  20'hFFFF, TYPED_NONE},
        '{STEP_ITEM, OP_FINISH, 16'h0000, 8'h00, REG_ENTRY_LIMIT, 20'h0, TYPED_GO_FFFF},
        '{STEP_REG,  OP_DATA,   16'h0000, 8'h00, REG_GO_ADDRESS,  20'h0, TYPED_NONE},
        // A write to the unused index must leave every register alone.
        '{STEP_REG,  OP_DATA,   16'h0000, 8'h00, REG_UNUSED,      20'hFFFFF, TYPED_NONE},
        '{STEP_ITEM, OP_DATA,   16'h8000, 8'h3C, REG_ENTRY_LIMIT, 20'h0, TYPED_NONE},
        '{STEP_ITEM, OP_FINISH, 16'h0000, 8'h00, REG_ENTRY_LIMIT, 20'h0, TYPED_NONE},
        // With a zero entry limit every byte is dropped.
        '{STEP_REG,  OP_DATA,   16'h0000, 8'h00, REG_ENTRY_LIMIT, 20'h0, TYPED_NONE},
        '{STEP_ITEM, OP_DATA,   16'h0010, 8'h11, REG_ENTRY_LIMIT, 20'h0, TYPED_NONE},
        '{STEP_ITEM, OP_FINISH, 16'h0000, 8'h00, REG_ENTRY_LIMIT, 20'h0, TYPED_GO_ZERO},
        // A limit of two keeps the first two bytes and drops the third.
        '{STEP_REG,  OP_DATA,   16'h0000, 8'h00, REG_ENTRY_LIMIT, 20'h2, TYPED_NONE},
        '{STEP_ITEM, OP_DATA,   16'h0020, 8'h01, REG_ENTRY_LIMIT, 20'h0, TYPED_NONE},
        '{STEP_ITEM, OP_DATA,   16'h0021, 8'h02, REG_ENTRY_LIMIT, 20'h0, TYPED_NONE},
        '{STEP_ITEM, OP_DATA,   16'h0022, 8'h03, REG_ENTRY_LIMIT, 20'h0, TYPED_NONE},
        '{STEP_ITEM, OP_FINISH, 16'h0000, 8'h00, REG_ENTRY_LIMIT, 20'h0, TYPED_NONE},
        '{STEP_REG,  OP_DATA,   16'h0000, 8'h00, REG_GO_ENABLE,   20'h0, TYPED_NONE},
        '{STEP_REG,  OP_DATA,   16'h0000, 8'h00, REG_ENTRY_LIMIT, 20'h10000, TYPED_NONE}
    };

    // Block ports.
    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic               op;
    logic [ADDR_W-1:0]  addr;
    logic [BYTE_W-1:0]  value;
    logic               out_valid;
    logic               out_ready;
    logic [TEXT_W-1:0]  out_text;
    logic [CNT_W-1:0]   out_count;
    logic               out_line_end;
    logic               out_last;

    // Expectation chosen by the sender for the item it is offering.
    t_typed_sel         typed_sel;

    // Predictor copy of the registers.
    logic [LIMIT_W-1:0] limit_reg;
    logic               go_en_reg;
    logic [ADDR_W-1:0]  go_ip_reg;

    // Predictor copy of the open line and the image.
    logic [7:0]         line_data [LINE_BYTES];
    logic [LCNT_W-1:0]  line_fill;
    logic [ADDR_W-1:0]  line_base;
    logic [ADDR_W-1:0]  last_addr;
    logic [7:0]         byte_sum;
    logic [LIMIT_W-1:0] image_bytes;

    // Characters of the record being built, the chunks of the current item,
    // and the chunks still owed by the block, oldest first.
    logic [7:0]         rec_buf [$];
    t_hex_chunk         item_chunks [$];
    t_hex_chunk         text_due [$];

    int                 mismatch_count = 0;
    int                 taken_items = 0;
    int                 quiet_cycles = 0;
    bit                 hold_armed = 1'b0;

    intel_hex_record_writer_unit dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_op         (op),
        .i_addr       (addr),
        .i_value      (value),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_text       (out_text),
        .o_char_count (out_count),
        .o_line_end   (out_line_end),
        .o_last       (out_last)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Appends the value as upper-case hex, most significant digit first.
    function automatic void put_hex(input logic [15:0] v, input int digits);
        logic [3:0] nib;
        for (int i = digits - 1; i >= 0; i--) begin
            nib = v[4*i +: 4];
            rec_buf.push_back(HEX_DIGITS[8 * (15 - int'(nib)) +: 8]);
        end
    endfunction

    // Cuts the finished record into chunks of up to eight characters. The
    // record always opens a fresh chunk, and its final chunk carries the
    // newline and the line end flag.
    function automatic void stage_record();
        t_hex_chunk c;
        int         k;
        c = '0;
        k = 0;
        for (int i = 0; i < rec_buf.size(); i++) begin
            c.text[8*k +: 8] = rec_buf[i];
            k++;
            if (k == 8 || i == rec_buf.size() - 1) begin
                c.count    = CNT_W'(k);
                c.line_end = (i == rec_buf.size() - 1);
                c.last     = 1'b0;
                item_chunks.push_back(c);
                c = '0;
                k = 0;
            end
        end
        rec_buf.delete();
    endfunction

    // Emits the open line as a data record, if it holds anything.
    function automatic void flush_open_line();
        logic [7:0] ck;
        if (line_fill == 0) begin
            return;
        end
        rec_buf.push_back(CH_COLON);
        put_hex(16'(line_fill), 2);
        put_hex(line_base, 4);
        put_hex(16'(REC_TYPE_DATA), 2);
        for (int i = 0; i < int'(line_fill); i++) begin
            put_hex(16'(line_data[i]), 2);
        end
        ck = 8'(0 - (int'(byte_sum) + int'(line_fill) + int'(line_base[15:8])
                     + int'(line_base[7:0])));
        put_hex(16'(ck), 2);
        rec_buf.push_back(CH_NL);
        stage_record();
        line_fill = '0;
        byte_sum  = '0;
    endfunction

    // Works out the chunks one input item causes and leaves them in
    // item_chunks. Returns 0 when a data byte is dropped at the entry limit.
    function automatic bit predict_item(input logic op_bit,
                                        input logic [ADDR_W-1:0] a,
                                        input logic [BYTE_W-1:0] v);
        logic [7:0] ck;
        item_chunks.delete();
        if (op_bit == OP_DATA) begin
            if (image_bytes >= limit_reg) begin
                return 1'b0;
            end
            image_bytes++;
            // A byte that does not follow the previous one, including the
            // step from 0xFFFF to 0x0000, closes the open line first.
            if (line_fill != 0 && (last_addr == 16'hFFFF || a != last_addr + 16'd1)) begin
                flush_open_line();
            end
            if (line_fill == 0) begin
                line_base = a;
                byte_sum  = '0;
            end
            line_data[line_fill] = v;
            line_fill++;
            byte_sum += v;
            last_addr = a;
            if (line_fill >= LINE_BYTES) begin
                flush_open_line();
            end
        end else begin
            flush_open_line();
            if (go_en_reg) begin
                rec_buf.push_back(CH_COLON);
                put_hex(16'(START_LENGTH), 2);
                put_hex(16'h0000, 4);
                put_hex(16'(REC_TYPE_START), 2);
                put_hex(16'h0000, 4);
                put_hex(go_ip_reg, 4);
                ck = 8'(0 - (int'(START_LENGTH) + int'(REC_TYPE_START)
                             + int'(go_ip_reg[15:8]) + int'(go_ip_reg[7:0])));
                put_hex(16'(ck), 2);
                rec_buf.push_back(CH_NL);
                stage_record();
            end
            rec_buf.push_back(CH_COLON);
            put_hex(16'h00, 2);
            put_hex(16'h0000, 4);
            put_hex(16'(REC_TYPE_EOF), 2);
            put_hex(16'hFF, 2);
            rec_buf.push_back(CH_NL);
            stage_record();
            line_fill   = '0;
            line_base   = '0;
            last_addr   = '0;
            byte_sum    = '0;
            image_bytes = '0;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Observer: everything the block does is seen here at the rising edge.
    // Output transfers are checked before the input transfer of the same
    // edge is predicted, so the order of the two never matters.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : observe
        t_hex_chunk want;
        t_hex_chunk tail;
        string      typed;
        if (!rst_n) begin
            limit_reg   = ENTRY_LIMIT_RST;
            go_en_reg   = 1'b0;
            go_ip_reg   = '0;
            line_fill   = '0;
            line_base   = '0;
            last_addr   = '0;
            byte_sum    = '0;
            image_bytes = '0;
            text_due.delete();
            quiet_cycles = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (text_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("%0t: output transfer with nothing expected: text=%h count=%0d",
                                 $realtime, out_text, out_count);
                    end
                end else begin
                    want = text_due.pop_front();
                    if (out_text !== want.text || out_count !== want.count
                        || out_line_end !== want.line_end || out_last !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX) begin
                            $display("%0t: mismatch: expected text=%h count=%0d end=%0b last=%0b",
                                     $realtime, want.text, want.count, want.line_end,
                                     want.last);
                            $display("%0t:           actual   text=%h count=%0d end=%0b last=%0b",
                                     $realtime, out_text, out_count, out_line_end, out_last);
                        end
                    end
                end
            end

            // Register writes land in the predictor at the same edge as in
            // the block. Bits above each register's width are dropped.
            if (cfg_we) begin
                case (cfg_index)
                    REG_ENTRY_LIMIT: limit_reg = cfg_data[LIMIT_W-1:0];
                    REG_GO_ENABLE:   go_en_reg = cfg_data[0];
                    REG_GO_ADDRESS:  go_ip_reg = cfg_data[ADDR_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready) begin
                // Every input transfer counts, dropped bytes included.
                void'(predict_item(op, addr, value));
                taken_items++;
                // A hand-written expectation replaces the predicted text.
                if (typed_sel != TYPED_NONE) begin
                    case (typed_sel)
                        TYPED_EOF:       typed = ":00000001FF\n";
                        TYPED_FFFF_LINE: typed = ":01FFFF00FF02\n:00000001FF\n";
                        TYPED_GO_FFFF:   typed = ":040000030000FFFFFB\n:00000001FF\n";
                        default:         typed = ":0400000300000000F9\n:00000001FF\n";
                    endcase
                    item_chunks.delete();
                    for (int i = 0; i < typed.len(); i++) begin
                        rec_buf.push_back(typed[i]);
                        if (typed[i] == CH_NL) begin
                            stage_record();
                        end
                    end
                end
                if (item_chunks.size() != 0) begin
                    tail = item_chunks.pop_back();
                    tail.last = 1'b1;
                    item_chunks.push_back(tail);
                end
                foreach (item_chunks[i]) begin
                    text_due.push_back(item_chunks[i]);
                end
            end

            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Idle length: mostly none, sometimes short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) begin
            return 0;
        end else if (r < 18) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Offers one item and returns at the falling edge after its transfer.
    // Valid stays high so that a back-to-back item only swaps the payload;
    // the next caller either replaces the payload or lowers valid.
    task automatic send_item(input logic op_bit, input logic [ADDR_W-1:0] a,
                             input logic [BYTE_W-1:0] v, input t_typed_sel sel,
                             input int gap);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        op        = op_bit;
        addr      = a;
        value     = v;
        typed_sel = sel;
        in_valid  = 1'b1;
        forever begin
            @(posedge clk);
            if (in_ready) begin
                break;
            end
        end
        @(negedge clk);
    endtask

    // Registers change only while the block is idle: every expected chunk
    // has arrived, and a settling wait of SETTLE_CYCLES covers a byte that is
    // still being written into the line buffer without causing output.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        in_valid = 1'b0;
        while (text_due.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sender: reset, the directed table, then randomized images.
    // ------------------------------------------------------------------
    initial begin : stimulus
        int                 target;
        int                 budget;
        int                 tries;
        int                 run_len;
        int                 pick;
        logic [ADDR_W-1:0]  run_addr;
        logic [LIMIT_W-1:0] limit_pick;
        logic [ADDR_W-1:0]  go_pick;
        bit                 steady;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_ENTRY_LIMIT;
        cfg_data  = '0;
        in_valid  = 1'b0;
        op        = OP_DATA;
        addr      = '0;
        value     = '0;
        typed_sel = TYPED_NONE;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == STEP_REG) begin
                write_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_data);
            end else begin
                send_item(DIRECTED[i].op_bit, DIRECTED[i].addr_val, DIRECTED[i].data_val,
                          DIRECTED[i].typed, pick_gap());
            end
        end

        // Each random image gets its own settings, extremes included, and
        // is built mostly from sequential runs so that lines fill, break
        // and wrap; scattered bytes and early finishes are the noise. The
        // last image is cut short once the item count is reached.
        target = taken_items + RANDOM_ITEMS;
        while (taken_items < target) begin
            case ($urandom_range(0, 5))
                0:       limit_pick = '0;
                1:       limit_pick = '1;
                2:       limit_pick = LIMIT_W'($urandom_range(1, 40));
                3:       limit_pick = ENTRY_LIMIT_RST;
                default: limit_pick = LIMIT_W'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       go_pick = 16'hFFFF;
                1:       go_pick = 16'h0000;
                default: go_pick = ADDR_W'($urandom);
            endcase
            write_reg(REG_ENTRY_LIMIT, limit_pick);
            write_reg(REG_GO_ENABLE, CFG_W'($urandom));
            write_reg(REG_GO_ADDRESS, {4'($urandom), go_pick});
            if ($urandom_range(0, 7) == 0) begin
                write_reg(REG_UNUSED, CFG_W'($urandom));
            end

            // The receiver starts its long hold-off once this is set.
            hold_armed = 1'b1;
            steady = ($urandom_range(0, 3) == 0);
            budget = (limit_pick == 0) ? $urandom_range(3, 8) : $urandom_range(20, 90);
            tries  = 0;
            while (tries < budget && taken_items < target) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    send_item(OP_FINISH, ADDR_W'($urandom), BYTE_W'($urandom), TYPED_NONE,
                              steady ? 0 : pick_gap());
                    tries++;
                end else if (pick < 4) begin
                    send_item(OP_DATA, ADDR_W'($urandom), BYTE_W'($urandom), TYPED_NONE,
                              steady ? 0 : pick_gap());
                    tries++;
                end else begin
                    if (pick == 4) begin
                        run_addr = ADDR_W'(16'hFFFF - $urandom_range(0, 40));
                    end else begin
                        run_addr = ADDR_W'($urandom);
                    end
                    if ($urandom_range(0, 3) == 0) begin
                        run_len = $urandom_range(30, 70);
                    end else begin
                        run_len = $urandom_range(1, 12);
                    end
                    if (run_len > target - taken_items) begin
                        run_len = target - taken_items;
                    end
                    repeat (run_len) begin
                        send_item(OP_DATA, run_addr, BYTE_W'($urandom), TYPED_NONE,
                                  steady ? 0 : pick_gap());
                        run_addr++;
                    end
                    tries += run_len;
                end
            end
            send_item(OP_FINISH, ADDR_W'($urandom), BYTE_W'($urandom), TYPED_NONE,
                      steady ? 0 : pick_gap());
        end

        in_valid = 1'b0;
        while (text_due.size() != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && text_due.size() == 0) begin
            $display("intel_hex_record_writer_unit test passed");
        end else begin
            $display("intel_hex_record_writer_unit test failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: ready in random bursts with short and long gaps. Once the
    // random part begins it holds off for a long stretch while the sender
    // keeps offering items, so the block fills up and stalls its input.
    // ------------------------------------------------------------------
    initial begin : receiver
        int  gap;
        int  run;
        bit  hold_done;
        hold_done = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_armed && !hold_done) begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            out_ready = 1'b1;
            if ($urandom_range(0, 7) == 0) begin
                run = $urandom_range(30, 80);
            end else begin
                run = $urandom_range(1, 6);
            end
            repeat (run) @(negedge clk);
            gap = pick_gap();
            if (gap > 0) begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    end

    // Watchdog: too many cycles in a row without any transfer means the
    // block has hung.
    initial begin : watchdog
        wait (rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(negedge clk);
        end
        $display("%0t: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("intel_hex_record_writer_unit test failed");
        $finish;
    end

endmodule
